FILE: design/tdcc_pkg.sv
// shared types and constants for the tdc bin time calibration core
`default_nettype none

package tdcc_pkg;

  // calibration rule selected by the cal_kind register
  typedef enum logic [1:0] {
    KIND_EXACT  = 2'd0,
    KIND_LINEAR = 2'd1,
    KIND_PLUS1  = 2'd2
  } cal_kind_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_CAL_KIND = 2'd0,
    CFG_ENTRIES  = 2'd1
  } cfg_reg_t;

  localparam int unsigned ENTRIES_W = 9;
  localparam int unsigned INDEX_W   = 8;
  localparam int unsigned VAL_W     = 32;

  // -10000.0 in signed q16.16
  localparam logic [VAL_W-1:0] NO_MATCH_TIME = 32'hD8F0_0000;
  localparam logic [VAL_W-1:0] S32_MAX       = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] S32_MIN       = 32'h8000_0000;

  // search token control bits handed from cell to cell
  typedef struct packed {
    logic vld;
    logic hit;
  } tok_ctl_t;

endpackage

`default_nettype wire

FILE: design/tdc_bin_time_calibration_core.sv
// top level of the tdc bin time calibration core
`default_nettype none

// Converts raw tdc bins to signed q16.16 times through a table of TABLE_DEPTH
// entries (low bin, high bin, q8.24 slope, q16.16 offset). Each entry lives in
// its own cell of a row; a convert beat launches a search token that walks the
// row one cell per cycle, the first enabled cell (index below entries_in_use)
// that matches under cal_kind loads its entry into the token, and a three
// stage unit at the end forms offset + round(slope * count) with saturation.
// Exact kinds (0 and 2) use a zero count so the answer is the offset itself.
// No match gives -10000.0 with matched low. A write beat (tuser high) loads one
// entry and gives no result; entry_index at or above TABLE_DEPTH is dropped.
// One item is in flight at a time: after a convert beat is accepted, the next
// beat is taken only once the token has walked the cell row and passed the
// arithmetic stages. The result sits in an output register, so a stalled
// consumer only holds the core once the following result is ready. Entries
// have no reset and must be written before they are searched. Configuration
// writes are taken at any time but are meant for idle periods only.

module tdc_bin_time_calibration_core #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned BIN_BITS    = 12
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // configuration write channel
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [tdcc_pkg::ENTRIES_W-1:0] cfg_data,
  // input stream
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  // tdata from bit 0: raw_bin, entry_index, entry_low, entry_high,
  // entry_slope, entry_offset, zero pad to whole bytes
  input  wire logic [((3*BIN_BITS+74+7)/8)*8-1:0] in_tdata,
  // tuser: mode (0 convert, 1 write entry)
  input  wire logic                    in_tuser,
  // result stream
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  // tdata: cal_time
  output logic [tdcc_pkg::VAL_W-1:0]   out_tdata,
  // tuser: matched
  output logic                         out_tuser
);

  localparam int unsigned BW      = BIN_BITS + 1;
  localparam int unsigned IDX_LO  = BIN_BITS;
  localparam int unsigned LOW_LO  = IDX_LO + tdcc_pkg::INDEX_W;
  localparam int unsigned HIGH_LO = LOW_LO + BW;
  localparam int unsigned SLP_LO  = HIGH_LO + BW;
  localparam int unsigned OFF_LO  = SLP_LO + tdcc_pkg::VAL_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_BUSY = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t                           state_r, state_nxt;
  tdcc_pkg::cal_kind_t              cal_kind_r;
  logic [tdcc_pkg::ENTRIES_W-1:0]   entries_r;
  logic                             out_vld_r, out_vld_nxt;
  logic [tdcc_pkg::VAL_W-1:0]       out_time_r;
  logic                             out_hit_r;

  logic in_acc;
  logic wr_en;
  logic out_free;
  logic load;

  // token row, slot i feeds cell i
  tdcc_pkg::tok_ctl_t               ctl_w    [0:TABLE_DEPTH];
  logic [BIN_BITS-1:0]              raw_w    [0:TABLE_DEPTH];
  logic [tdcc_pkg::VAL_W-1:0]       slope_w  [0:TABLE_DEPTH];
  logic [tdcc_pkg::VAL_W-1:0]       offset_w [0:TABLE_DEPTH];
  logic [BIN_BITS:0]                count_w  [0:TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]           chain_vld;

  logic                             lin_vld;
  logic                             lin_hit;
  logic [tdcc_pkg::VAL_W-1:0]       lin_time;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign wr_en     = in_acc && in_tuser;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_kind_r <= tdcc_pkg::KIND_EXACT;
      entries_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tdcc_pkg::CFG_CAL_KIND: cal_kind_r <= tdcc_pkg::cal_kind_t'(cfg_data[1:0]);
        tdcc_pkg::CFG_ENTRIES:  entries_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // token launch
  assign ctl_w[0].vld = in_acc && !in_tuser;
  assign ctl_w[0].hit = 1'b0;
  assign raw_w[0]     = in_tdata[BIN_BITS-1:0];
  assign slope_w[0]   = '0;
  assign offset_w[0]  = '0;
  assign count_w[0]   = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    tdcc_cell #(
      .IDX      (i),
      .BIN_BITS (BIN_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .kind      (cal_kind_r),
      .entries   (entries_r),
      .wr_en     (wr_en),
      .wr_idx    (in_tdata[LOW_LO-1:IDX_LO]),
      .wr_low    (in_tdata[HIGH_LO-1:LOW_LO]),
      .wr_high   (in_tdata[SLP_LO-1:HIGH_LO]),
      .wr_slope  (in_tdata[OFF_LO-1:SLP_LO]),
      .wr_offset (in_tdata[OFF_LO+tdcc_pkg::VAL_W-1:OFF_LO]),
      .ctl_i     (ctl_w[i]),
      .raw_i     (raw_w[i]),
      .slope_i   (slope_w[i]),
      .offset_i  (offset_w[i]),
      .count_i   (count_w[i]),
      .ctl_o     (ctl_w[i+1]),
      .raw_o     (raw_w[i+1]),
      .slope_o   (slope_w[i+1]),
      .offset_o  (offset_w[i+1]),
      .count_o   (count_w[i+1])
    );
    assign chain_vld[i] = ctl_w[i+1].vld;
  end

  tdcc_lin #(
    .BIN_BITS (BIN_BITS)
  ) u_lin (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (ctl_w[TABLE_DEPTH]),
    .slope_i  (slope_w[TABLE_DEPTH]),
    .offset_i (offset_w[TABLE_DEPTH]),
    .count_i  (count_w[TABLE_DEPTH]),
    .vld_o    (lin_vld),
    .hit_o    (lin_hit),
    .time_o   (lin_time)
  );

  // sequencing and output register
  assign out_free = !out_vld_r || out_tready;
  assign load     = out_free && ((state_r == S_HOLD) || ((state_r == S_BUSY) && lin_vld));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && !in_tuser) state_nxt = S_BUSY;
      end
      S_BUSY: begin
        if (lin_vld) state_nxt = out_free ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_time_r <= lin_time;
      out_hit_r  <= lin_hit;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_time_r;
  assign out_tuser  = out_hit_r;

  // at most one search token in the cell row
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_vld))
    else $error("more than one search token in the cell row");

  // arithmetic results only appear while a search is outstanding
  a_lin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    lin_vld |-> (state_r == S_BUSY))
    else $error("result from arithmetic unit while not busy");

  // a table write never launches a search
  a_wr_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> !chain_vld[0])
    else $error("write beat launched a search token");

  // unmatched results carry the no match time
  a_nomatch_time: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == tdcc_pkg::NO_MATCH_TIME))
    else $error("unmatched result with wrong time");

endmodule

`default_nettype wire

FILE: design/tdcc_cell.sv
// one table entry of the search row plus its stage of the search token
`default_nettype none

module tdcc_cell #(
  parameter int unsigned IDX      = 0,
  parameter int unsigned BIN_BITS = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire tdcc_pkg::cal_kind_t                 kind,
  input  wire logic [tdcc_pkg::ENTRIES_W-1:0]      entries,
  input  wire logic                                wr_en,
  input  wire logic [tdcc_pkg::INDEX_W-1:0]        wr_idx,
  input  wire logic [BIN_BITS:0]                   wr_low,
  input  wire logic [BIN_BITS:0]                   wr_high,
  input  wire logic [tdcc_pkg::VAL_W-1:0]          wr_slope,
  input  wire logic [tdcc_pkg::VAL_W-1:0]          wr_offset,
  input  wire tdcc_pkg::tok_ctl_t                  ctl_i,
  input  wire logic [BIN_BITS-1:0]                 raw_i,
  input  wire logic [tdcc_pkg::VAL_W-1:0]          slope_i,
  input  wire logic [tdcc_pkg::VAL_W-1:0]          offset_i,
  input  wire logic [BIN_BITS:0]                   count_i,
  output tdcc_pkg::tok_ctl_t                       ctl_o,
  output logic [BIN_BITS-1:0]                      raw_o,
  output logic [tdcc_pkg::VAL_W-1:0]               slope_o,
  output logic [tdcc_pkg::VAL_W-1:0]               offset_o,
  output logic [BIN_BITS:0]                        count_o
);

  // stored entry, undefined until written
  logic [BIN_BITS:0]            low_r;
  logic [BIN_BITS:0]            high_r;
  logic [tdcc_pkg::VAL_W-1:0]   slope_r;
  logic [tdcc_pkg::VAL_W-1:0]   offset_r;

  // token stage
  tdcc_pkg::tok_ctl_t           ctl_r;
  logic [BIN_BITS-1:0]          raw_r;
  logic [tdcc_pkg::VAL_W-1:0]   tslope_r;
  logic [tdcc_pkg::VAL_W-1:0]   toffset_r;
  logic [BIN_BITS:0]            count_r;

  logic                         active;
  logic                         match;
  logic [BIN_BITS:0]            raw_ext;
  logic [BIN_BITS:0]            v;
  logic [BIN_BITS:0]            cnt;
  logic                         take;

  assign active  = (32'(IDX) < 32'(entries));
  assign raw_ext = {1'b0, raw_i};
  assign v       = raw_ext + 1'b1;

  always_comb begin
    match = 1'b0;
    cnt   = '0;
    case (kind)
      tdcc_pkg::KIND_EXACT: begin
        match = (raw_ext == low_r);
      end
      tdcc_pkg::KIND_LINEAR: begin
        match = (v >= low_r) && (v <= high_r);
        cnt   = v - low_r;
      end
      tdcc_pkg::KIND_PLUS1: begin
        match = (v == low_r);
      end
      default: begin
        match = 1'b0;
      end
    endcase
  end

  // first matching entry wins, later cells pass the token through
  assign take = !ctl_i.hit && active && match;

  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_idx) == 32'(IDX))) begin
      low_r    <= wr_low;
      high_r   <= wr_high;
      slope_r  <= wr_slope;
      offset_r <= wr_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r.vld <= ctl_i.vld;
      ctl_r.hit <= ctl_i.vld && (ctl_i.hit || take);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.vld) begin
      raw_r <= raw_i;
      if (take) begin
        tslope_r  <= slope_r;
        toffset_r <= offset_r;
        count_r   <= cnt;
      end else begin
        tslope_r  <= slope_i;
        toffset_r <= offset_i;
        count_r   <= count_i;
      end
    end
  end

  assign ctl_o    = ctl_r;
  assign raw_o    = raw_r;
  assign slope_o  = tslope_r;
  assign offset_o = toffset_r;
  assign count_o  = count_r;

endmodule

`default_nettype wire

FILE: design/tdcc_lin.sv
// three stage slope times count, rounding, offset add and saturation
`default_nettype none

module tdcc_lin #(
  parameter int unsigned BIN_BITS = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tdcc_pkg::tok_ctl_t          ctl_i,
  input  wire logic [tdcc_pkg::VAL_W-1:0]  slope_i,
  input  wire logic [tdcc_pkg::VAL_W-1:0]  offset_i,
  input  wire logic [BIN_BITS:0]           count_i,
  output logic                             vld_o,
  output logic                             hit_o,
  output logic [tdcc_pkg::VAL_W-1:0]       time_o
);

  localparam int unsigned CW = BIN_BITS + 1;
  localparam int unsigned PW = tdcc_pkg::VAL_W + CW + 1;
  localparam int unsigned QW = PW - 8;

  logic                         s1_vld_r;
  logic                         s1_hit_r;
  logic signed [PW-1:0]         s1_prod_r;
  logic [tdcc_pkg::VAL_W-1:0]   s1_off_r;

  logic                         s2_vld_r;
  logic                         s2_hit_r;
  logic [tdcc_pkg::VAL_W-1:0]   s2_prod_r;
  logic [tdcc_pkg::VAL_W-1:0]   s2_off_r;

  logic                         vld_r;
  logic                         hit_r;
  logic [tdcc_pkg::VAL_W-1:0]   time_r;

  logic signed [PW-1:0]         prod;
  logic signed [PW-1:0]         rnd;
  logic signed [QW-1:0]         q;
  logic [tdcc_pkg::VAL_W-1:0]   prod_sat;
  logic [tdcc_pkg::VAL_W:0]     sum;
  logic [tdcc_pkg::VAL_W-1:0]   sum_sat;

  assign prod = $signed(slope_i) * $signed({1'b0, count_i});

  // round to nearest, ties up: add half an lsb then floor shift
  assign rnd = s1_prod_r + PW'(128);
  assign q   = QW'(rnd >>> 8);

  always_comb begin
    if ((q[QW-1:tdcc_pkg::VAL_W-1] == '0) || (q[QW-1:tdcc_pkg::VAL_W-1] == '1)) begin
      prod_sat = q[tdcc_pkg::VAL_W-1:0];
    end else if (q[QW-1]) begin
      prod_sat = tdcc_pkg::S32_MIN;
    end else begin
      prod_sat = tdcc_pkg::S32_MAX;
    end
  end

  assign sum = {s2_off_r[tdcc_pkg::VAL_W-1], s2_off_r}
             + {s2_prod_r[tdcc_pkg::VAL_W-1], s2_prod_r};

  always_comb begin
    if (sum[tdcc_pkg::VAL_W] == sum[tdcc_pkg::VAL_W-1]) begin
      sum_sat = sum[tdcc_pkg::VAL_W-1:0];
    end else if (sum[tdcc_pkg::VAL_W]) begin
      sum_sat = tdcc_pkg::S32_MIN;
    end else begin
      sum_sat = tdcc_pkg::S32_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      vld_r    <= 1'b0;
    end else begin
      s1_vld_r <= ctl_i.vld;
      s2_vld_r <= s1_vld_r;
      vld_r    <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.vld) begin
      s1_hit_r  <= ctl_i.hit;
      s1_prod_r <= prod;
      s1_off_r  <= offset_i;
    end
    if (s1_vld_r) begin
      s2_hit_r  <= s1_hit_r;
      s2_prod_r <= prod_sat;
      s2_off_r  <= s1_off_r;
    end
    if (s2_vld_r) begin
      hit_r  <= s2_hit_r;
      time_r <= s2_hit_r ? sum_sat : tdcc_pkg::NO_MATCH_TIME;
    end
  end

  assign vld_o  = vld_r;
  assign hit_o  = hit_r;
  assign time_o = time_r;

endmodule

`default_nettype wire
